[rtl/sdas_pkg.sv]
// ----------------------------------------------------------------------------
// sdas_pkg
// Shared types and codes of the drill axis sequencer.
// ----------------------------------------------------------------------------
package sdas_pkg;

	localparam int CfgIndexW = 2;
	localparam int CfgDataW  = 16;
	localparam int InDataW   = 8;
	localparam int OutDataW  = 8;

	// Register indexes of the configuration port
	typedef enum logic [CfgIndexW-1:0] {
		REG_DRILL_STEP_LIMIT   = 2'd0,
		REG_JOG_BURST_STEPS    = 2'd1,
		REG_HALF_PERIOD_TICKS  = 2'd2,
		REG_RELEASE_POLL_TICKS = 2'd3
	} sdas_reg_t;

	localparam logic [15:0] DrillStepLimitRst   = 16'd6400;
	localparam logic [7:0]  JogBurstStepsRst    = 8'd50;
	localparam logic [7:0]  HalfPeriodTicksRst  = 8'd1;
	localparam logic [7:0]  ReleasePollTicksRst = 8'd10;

	// Remote command codes; anything above CMD_STOP is ignored
	localparam logic [2:0] CMD_FWD   = 3'd0;
	localparam logic [2:0] CMD_BACK  = 3'd1;
	localparam logic [2:0] CMD_DRILL = 3'd2;
	localparam logic [2:0] CMD_STOP  = 3'd3;

	typedef struct packed {
		logic [15:0] drill_step_limit;
		logic [7:0]  jog_burst_steps;
		logic [7:0]  half_period_ticks;
		logic [7:0]  release_poll_ticks;
	} sdas_cfg_t;

	typedef struct packed {
		logic [2:0] remote_cmd;
		logic       remote_valid;
		logic       end_switch_level;
		logic       drill_pressed;
		logic       back_pressed;
		logic       fwd_pressed;
	} sdas_item_t;

	typedef struct packed {
		logic [3:0] mode_now;
		logic       spindle_on;
		logic       dir_out;
		logic       step_out;
	} sdas_result_t;

endpackage

[rtl/sdas_cfg_regs.sv]
// ----------------------------------------------------------------------------
// sdas_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module sdas_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sdas_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [sdas_pkg::CfgDataW-1:0]  cfg_data,
	output sdas_pkg::sdas_cfg_t           cfg
);
	import sdas_pkg::*;

	sdas_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drill_step_limit   <= DrillStepLimitRst;
			cfg_q.jog_burst_steps    <= JogBurstStepsRst;
			cfg_q.half_period_ticks  <= HalfPeriodTicksRst;
			cfg_q.release_poll_ticks <= ReleasePollTicksRst;
		end else if (cfg_we) begin
			unique case (sdas_reg_t'(cfg_index))
				REG_DRILL_STEP_LIMIT:   cfg_q.drill_step_limit   <= cfg_data;
				REG_JOG_BURST_STEPS:    cfg_q.jog_burst_steps    <= cfg_data[7:0];
				REG_HALF_PERIOD_TICKS:  cfg_q.half_period_ticks  <= cfg_data[7:0];
				REG_RELEASE_POLL_TICKS: cfg_q.release_poll_ticks <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/sdas_core.sv]
// ----------------------------------------------------------------------------
// sdas_core
// Motion state registers and the per-tick next-state logic.
// ----------------------------------------------------------------------------
module sdas_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  sdas_pkg::sdas_item_t    item,
	input  sdas_pkg::sdas_cfg_t     cfg,
	output sdas_pkg::sdas_result_t  result
);
	import sdas_pkg::*;

	typedef enum logic [3:0] {
		MODE_IDLE      = 4'd0,
		MODE_JOG_FWD   = 4'd1,
		MODE_JOG_BACK  = 4'd2,
		MODE_RMT_FWD   = 4'd3,
		MODE_RMT_BACK  = 4'd4,
		MODE_SEEK      = 4'd5,
		MODE_BACKOFF   = 4'd6,
		MODE_DESCEND   = 4'd7,
		MODE_STOP_WAIT = 4'd8
	} mode_t;

	localparam logic [1:0] AH_IDLE        = 2'd0;
	localparam logic [1:0] AH_DESCEND     = 2'd1;
	localparam logic [1:0] AH_SPINDLE_OFF = 2'd2;

	mode_t       mode_q,        mode_d;
	logic [1:0]  after_home_q,  after_home_d;
	logic        level_q,       level_d;
	logic [7:0]  tick_q,        tick_d;
	logic [15:0] step_cnt_q,    step_cnt_d;
	logic [7:0]  burst_q,       burst_d;
	logic        dir_q,         dir_d;
	logic        spindle_q,     spindle_d;
	logic        pend_valid_q,  pend_valid_d;
	logic [2:0]  pend_cmd_q,    pend_cmd_d;

	logic [7:0] half_m1;
	logic [7:0] poll_m1;
	logic [7:0] burst_len;
	logic       p_level;
	logic [7:0] p_tick;
	logic       boundary;
	logic       go;
	logic       f, b, d, sw;

	assign f  = item.fwd_pressed;
	assign b  = item.back_pressed;
	assign d  = item.drill_pressed;
	assign sw = item.end_switch_level;

	// zero-valued registers act as one
	assign half_m1   = (cfg.half_period_ticks == 8'd0) ? 8'd0 : cfg.half_period_ticks - 8'd1;
	assign poll_m1   = (cfg.release_poll_ticks == 8'd0) ? 8'd0 : cfg.release_poll_ticks - 8'd1;
	assign burst_len = (cfg.jog_burst_steps == 8'd0) ? 8'd1 : cfg.jog_burst_steps;

	// pulse generator advance; boundary marks the end of a low half period
	always_comb begin
		p_level  = level_q;
		p_tick   = tick_q;
		boundary = 1'b0;
		if (level_q) begin
			if (tick_q != 8'd0) begin
				p_tick = tick_q - 8'd1;
			end else begin
				p_level = 1'b0;
				p_tick  = half_m1;
			end
		end else if (tick_q != 8'd0) begin
			p_tick = tick_q - 8'd1;
		end else begin
			boundary = 1'b1;
		end
	end

	always_comb begin
		mode_d       = mode_q;
		after_home_d = after_home_q;
		level_d      = level_q;
		tick_d       = tick_q;
		step_cnt_d   = step_cnt_q;
		burst_d      = burst_q;
		dir_d        = dir_q;
		spindle_d    = spindle_q;
		pend_valid_d = pend_valid_q;
		pend_cmd_d   = pend_cmd_q;
		go           = 1'b0;

		// a newer command replaces one still pending
		if (item.remote_valid) begin
			pend_valid_d = 1'b1;
			pend_cmd_d   = item.remote_cmd;
		end

		unique case (mode_q)
			MODE_JOG_FWD, MODE_JOG_BACK: begin
				level_d = p_level;
				tick_d  = p_tick;
				if (boundary) begin
					if (burst_q == 8'd0) begin
						go = !pend_valid_d && ((mode_q == MODE_JOG_FWD) ?
							(f && !b) : (b && !f && !sw));
					end else begin
						go = 1'b1;
					end
					if (go) begin
						burst_d = ((burst_q == 8'd0) ? burst_len : burst_q) - 8'd1;
						level_d = 1'b1;
						tick_d  = half_m1;
					end else begin
						mode_d  = MODE_IDLE;
						level_d = 1'b0;
						tick_d  = 8'd0;
						burst_d = 8'd0;
					end
				end
			end
			MODE_RMT_FWD, MODE_RMT_BACK: begin
				level_d = p_level;
				tick_d  = p_tick;
				if (boundary) begin
					go = !pend_valid_d && !f && !b && !d && (mode_q == MODE_RMT_FWD || !sw);
					if (go) begin
						level_d = 1'b1;
						tick_d  = half_m1;
					end else begin
						mode_d  = MODE_IDLE;
						level_d = 1'b0;
						tick_d  = 8'd0;
						burst_d = 8'd0;
					end
				end
			end
			MODE_SEEK, MODE_BACKOFF: begin
				level_d = p_level;
				tick_d  = p_tick;
				if (boundary) begin
					go = !pend_valid_d && !f && !b && ((mode_q == MODE_SEEK) ? sw : !sw);
					if (go) begin
						level_d = 1'b1;
						tick_d  = half_m1;
					end else begin
						level_d = 1'b0;
						tick_d  = 8'd0;
						burst_d = 8'd0;
						if (mode_q == MODE_SEEK) begin
							dir_d  = 1'b1;
							mode_d = MODE_BACKOFF;
						end else if (after_home_q == AH_DESCEND) begin
							after_home_d = AH_IDLE;
							step_cnt_d   = 16'd0;
							dir_d        = 1'b0;
							mode_d       = MODE_DESCEND;
						end else begin
							if (after_home_q == AH_SPINDLE_OFF) begin
								spindle_d = 1'b0;
							end
							after_home_d = AH_IDLE;
							mode_d       = MODE_IDLE;
						end
					end
				end
			end
			MODE_DESCEND: begin
				level_d = p_level;
				tick_d  = p_tick;
				if (boundary) begin
					go = (step_cnt_q < cfg.drill_step_limit) &&
						!(step_cnt_q != 16'd0 && (f || b || pend_valid_d));
					if (go) begin
						step_cnt_d = step_cnt_q + 16'd1;
						level_d    = 1'b1;
						tick_d     = half_m1;
					end else begin
						after_home_d = AH_SPINDLE_OFF;
						dir_d        = 1'b0;
						mode_d       = MODE_SEEK;
						level_d      = 1'b0;
						tick_d       = 8'd0;
						burst_d      = 8'd0;
					end
				end
			end
			MODE_STOP_WAIT: begin
				level_d = 1'b0;
				if (tick_q != 8'd0) begin
					tick_d = tick_q - 8'd1;
				end else if (!f && !b) begin
					mode_d  = MODE_IDLE;
					tick_d  = 8'd0;
					burst_d = 8'd0;
				end else begin
					tick_d = poll_m1;
				end
			end
			default: begin
				// idle: pending remote command, then both buttons, fwd, back, drill
				after_home_d = AH_IDLE;
				mode_d       = MODE_IDLE;
				level_d      = 1'b0;
				tick_d       = 8'd0;
				burst_d      = 8'd0;
				if (pend_valid_d) begin
					pend_valid_d = 1'b0;
					if (pend_cmd_d == CMD_FWD || pend_cmd_d == CMD_BACK) begin
						spindle_d = 1'b1;
						dir_d     = (pend_cmd_d == CMD_BACK);
						mode_d    = (pend_cmd_d == CMD_BACK) ? MODE_RMT_BACK : MODE_RMT_FWD;
					end else if (pend_cmd_d == CMD_DRILL) begin
						spindle_d    = 1'b1;
						after_home_d = AH_DESCEND;
						dir_d        = 1'b0;
						mode_d       = MODE_SEEK;
					end else if (pend_cmd_d == CMD_STOP) begin
						spindle_d = 1'b0;
						mode_d    = MODE_STOP_WAIT;
					end
				end else if (f && b) begin
					spindle_d = 1'b0;
					mode_d    = MODE_STOP_WAIT;
				end else if (f || b) begin
					spindle_d = 1'b1;
					dir_d     = !f;
					mode_d    = f ? MODE_JOG_FWD : MODE_JOG_BACK;
				end else if (d) begin
					spindle_d    = 1'b1;
					after_home_d = AH_DESCEND;
					dir_d        = 1'b0;
					mode_d       = MODE_SEEK;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_SEEK;
			after_home_q <= AH_IDLE;
			level_q      <= 1'b0;
			tick_q       <= 8'd0;
			step_cnt_q   <= 16'd0;
			burst_q      <= 8'd0;
			dir_q        <= 1'b0;
			spindle_q    <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_cmd_q   <= 3'd0;
		end else if (advance) begin
			mode_q       <= mode_d;
			after_home_q <= after_home_d;
			level_q      <= level_d;
			tick_q       <= tick_d;
			step_cnt_q   <= step_cnt_d;
			burst_q      <= burst_d;
			dir_q        <= dir_d;
			spindle_q    <= spindle_d;
			pend_valid_q <= pend_valid_d;
			pend_cmd_q   <= pend_cmd_d;
		end
	end

	assign result.step_out   = level_d;
	assign result.dir_out    = dir_d;
	assign result.spindle_on = spindle_d;
	assign result.mode_now   = 4'(mode_d);

endmodule

[rtl/sdas_out_skid.sv]
// ----------------------------------------------------------------------------
// sdas_out_skid
// Output register with a skid stage, so one transaction can be taken while
// the receiver stalls.
// ----------------------------------------------------------------------------
module sdas_out_skid (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  sdas_pkg::sdas_result_t in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output sdas_pkg::sdas_result_t out_data
);
	import sdas_pkg::*;

	logic         out_valid_q;
	sdas_result_t out_data_q;
	logic         skid_valid_q;
	sdas_result_t skid_data_q;

	assign in_ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && in_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_data_q <= skid_valid_q ? skid_data_q : in_data;
		end else if (in_valid && in_ready) begin
			skid_data_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[rtl/stepper_drill_axis_sequencer.sv]
// ----------------------------------------------------------------------------
// stepper_drill_axis_sequencer
// Drill axis sequencer: jogging, homing, drill cycle and stop for a stepper
// axis with spindle motor, one tick per input transaction.
// ----------------------------------------------------------------------------
// Each transaction on s_axis is one timer tick carrying button states, the
// end switch level and an optional remote command. Each tick yields exactly
// one transaction on m_axis with step, direction, spindle and current mode.
// Registers must be written by the user through cfg_we / cfg_index / cfg_data
// only while idle; the block does not enforce it. Throughput: one tick per
// cycle while m_axis does not stall; the motion state update is a single
// combinational pass from the state registers into the output register.
// When m_axis stalls, one more tick is taken into the skid stage and then
// s_axis_tready drops until the receiver drains it.
// Reset (arst_n low) loads the register defaults and starts in homing seek
// with the spindle off and no remote command pending.
// ----------------------------------------------------------------------------
module stepper_drill_axis_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [0] fwd_pressed, [1] back_pressed, [2] drill_pressed,
	// [3] end_switch_level, [4] remote_valid, [7:5] remote_cmd
	input  logic [sdas_pkg::InDataW-1:0]  s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [0] step_out, [1] dir_out, [2] spindle_on, [6:3] mode_now, [7] zero
	output logic [sdas_pkg::OutDataW-1:0] m_axis_tdata,
	input  logic                          cfg_we,
	input  logic [sdas_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [sdas_pkg::CfgDataW-1:0]  cfg_data
);
	import sdas_pkg::*;

	sdas_cfg_t    cfg;
	sdas_item_t   item;
	sdas_result_t result;
	sdas_result_t out_result;
	logic         accept;

	assign item   = sdas_item_t'(s_axis_tdata);
	assign accept = s_axis_tvalid && s_axis_tready;

	sdas_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sdas_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.item    (item),
		.cfg     (cfg),
		.result  (result)
	);

	sdas_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (result),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_result)
	);

	assign m_axis_tdata = {1'b0, out_result};

endmodule

[dv/sdas_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdas_checker
// Watches the tick and output streams of the drill axis sequencer, keeps its
// own copy of the motion state, and compares every output transaction.
// ----------------------------------------------------------------------------
module sdas_checker
	import sdas_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [InDataW-1:0]    s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OutDataW-1:0]   m_axis_tdata,
	input  logic                  cfg_we,
	input  logic [CfgIndexW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0]   cfg_data,
	output int                    fail_count,
	output int                    outstanding,
	output int                    ticks_checked,
	output logic [15:0]           modes_hit
);

	localparam logic [3:0] MODE_IDLE      = 4'd0;
	localparam logic [3:0] MODE_JOG_FWD   = 4'd1;
	localparam logic [3:0] MODE_JOG_BACK  = 4'd2;
	localparam logic [3:0] MODE_RJOG_FWD  = 4'd3;
	localparam logic [3:0] MODE_RJOG_BACK = 4'd4;
	localparam logic [3:0] MODE_SEEK      = 4'd5;
	localparam logic [3:0] MODE_BACKOFF   = 4'd6;
	localparam logic [3:0] MODE_DESCEND   = 4'd7;
	localparam logic [3:0] MODE_STOP_WAIT = 4'd8;

	// what happens once homing completes
	localparam logic [1:0] HOME_TO_IDLE     = 2'd0;
	localparam logic [1:0] HOME_TO_DESCEND  = 2'd1;
	localparam logic [1:0] HOME_SPINDLE_OFF = 2'd2;

	sdas_cfg_t    cfg;
	logic [3:0]   cur_mode;
	logic [1:0]   home_next;
	logic         pulse_hi;
	logic [7:0]   pulse_timer;
	logic [15:0]  descent_steps;
	logic [7:0]   burst_left;
	logic         dir_q;
	logic         spindle_q;
	logic         cmd_waiting;
	logic [2:0]   cmd_held;

	sdas_result_t pending_results[$];
	sdas_result_t want;
	sdas_result_t got;

	function automatic logic [7:0] nz(input logic [7:0] v);
		return (v == 8'd0) ? 8'd1 : v;
	endfunction

	function automatic void enter_mode(input logic [3:0] m);
		cur_mode    = m;
		pulse_hi    = 1'b0;
		pulse_timer = 8'd0;
		burst_left  = 8'd0;
	endfunction

	// advances the step pulse, returns 1 on a step boundary
	function automatic logic pulse_boundary();
		if (pulse_hi) begin
			if (pulse_timer != 8'd0) begin
				pulse_timer--;
			end else begin
				pulse_hi    = 1'b0;
				pulse_timer = nz(cfg.half_period_ticks) - 8'd1;
			end
			return 1'b0;
		end
		if (pulse_timer != 8'd0) begin
			pulse_timer--;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void start_pulse();
		pulse_hi    = 1'b1;
		pulse_timer = nz(cfg.half_period_ticks) - 8'd1;
	endfunction

	function automatic void begin_drill();
		spindle_q = 1'b1;
		home_next = HOME_TO_DESCEND;
		dir_q     = 1'b0;
		enter_mode(MODE_SEEK);
	endfunction

	function automatic sdas_result_t sequencer_tick(input sdas_item_t it);
		logic f;
		logic b;
		logic d;
		logic sw;
		logic go;
		sdas_result_t r;
		f  = it.fwd_pressed;
		b  = it.back_pressed;
		d  = it.drill_pressed;
		sw = it.end_switch_level;
		go = 1'b0;
		if (it.remote_valid) begin
			cmd_waiting = 1'b1;
			cmd_held    = it.remote_cmd;
		end
		case (cur_mode)
			MODE_JOG_FWD, MODE_JOG_BACK: begin
				if (pulse_boundary()) begin
					go = 1'b1;
					// run condition is checked only when a burst starts
					if (burst_left == 8'd0) begin
						go = !cmd_waiting && ((cur_mode == MODE_JOG_FWD) ?
							(f && !b) : (b && !f && !sw));
						if (go)
							burst_left = nz(cfg.jog_burst_steps);
					end
					if (go) begin
						burst_left--;
						start_pulse();
					end else begin
						enter_mode(MODE_IDLE);
					end
				end
			end
			MODE_RJOG_FWD, MODE_RJOG_BACK: begin
				if (pulse_boundary()) begin
					go = !cmd_waiting && !f && !b && !d && (cur_mode == MODE_RJOG_FWD || !sw);
					if (go)
						start_pulse();
					else
						enter_mode(MODE_IDLE);
				end
			end
			MODE_SEEK, MODE_BACKOFF: begin
				if (pulse_boundary()) begin
					go = !cmd_waiting && !f && !b && ((cur_mode == MODE_SEEK) ? sw : !sw);
					if (go) begin
						start_pulse();
					end else if (cur_mode == MODE_SEEK) begin
						dir_q = 1'b1;
						enter_mode(MODE_BACKOFF);
					end else if (home_next == HOME_TO_DESCEND) begin
						home_next     = HOME_TO_IDLE;
						descent_steps = 16'd0;
						dir_q         = 1'b0;
						enter_mode(MODE_DESCEND);
					end else begin
						if (home_next == HOME_SPINDLE_OFF)
							spindle_q = 1'b0;
						home_next = HOME_TO_IDLE;
						enter_mode(MODE_IDLE);
					end
				end
			end
			MODE_DESCEND: begin
				if (pulse_boundary()) begin
					go = descent_steps < cfg.drill_step_limit;
					// first step ignores interruptions; later ones stop on any interruption
					if (descent_steps != 16'd0 && (f || b || cmd_waiting))
						go = 1'b0;
					if (go) begin
						descent_steps++;
						start_pulse();
					end else begin
						home_next = HOME_SPINDLE_OFF;
						dir_q     = 1'b0;
						enter_mode(MODE_SEEK);
					end
				end
			end
			MODE_STOP_WAIT: begin
				pulse_hi = 1'b0;
				if (pulse_timer != 8'd0)
					pulse_timer--;
				else if (!f && !b)
					enter_mode(MODE_IDLE);
				else
					pulse_timer = nz(cfg.release_poll_ticks) - 8'd1;
			end
			default: begin
				home_next = HOME_TO_IDLE;
				enter_mode(MODE_IDLE);
				if (cmd_waiting) begin
					cmd_waiting = 1'b0;
					case (cmd_held)
						CMD_FWD, CMD_BACK: begin
							spindle_q = 1'b1;
							dir_q     = (cmd_held == CMD_BACK);
							enter_mode((cmd_held == CMD_FWD) ? MODE_RJOG_FWD : MODE_RJOG_BACK);
						end
						CMD_DRILL: begin
							begin_drill();
						end
						CMD_STOP: begin
							spindle_q = 1'b0;
							enter_mode(MODE_STOP_WAIT);
						end
						default: ;
					endcase
				end else if (f && b) begin
					spindle_q = 1'b0;
					enter_mode(MODE_STOP_WAIT);
				end else if (f || b) begin
					spindle_q = 1'b1;
					dir_q     = !f;
					enter_mode(f ? MODE_JOG_FWD : MODE_JOG_BACK);
				end else if (d) begin
					begin_drill();
				end
			end
		endcase
		r            = '0;
		r.step_out   = pulse_hi;
		r.dir_out    = dir_q;
		r.spindle_on = spindle_q;
		r.mode_now   = cur_mode;
		return r;
	endfunction

	function automatic void cmp_field(input string name, input int want_v, input int got_v);
		if (want_v != got_v) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.drill_step_limit   = DrillStepLimitRst;
			cfg.jog_burst_steps    = JogBurstStepsRst;
			cfg.half_period_ticks  = HalfPeriodTicksRst;
			cfg.release_poll_ticks = ReleasePollTicksRst;
			cur_mode      = MODE_SEEK;
			home_next     = HOME_TO_IDLE;
			pulse_hi      = 1'b0;
			pulse_timer   = 8'd0;
			descent_steps = 16'd0;
			burst_left    = 8'd0;
			dir_q         = 1'b0;
			spindle_q     = 1'b0;
			cmd_waiting   = 1'b0;
			cmd_held      = CMD_FWD;
			pending_results.delete();
			fail_count    = 0;
			outstanding   = 0;
			ticks_checked = 0;
			modes_hit     = '0;
		end else begin
			if (cfg_we) begin
				case (sdas_reg_t'(cfg_index))
					REG_DRILL_STEP_LIMIT:   cfg.drill_step_limit   = cfg_data;
					REG_JOG_BURST_STEPS:    cfg.jog_burst_steps    = cfg_data[7:0];
					REG_HALF_PERIOD_TICKS:  cfg.half_period_ticks  = cfg_data[7:0];
					REG_RELEASE_POLL_TICKS: cfg.release_poll_ticks = cfg_data[7:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = sdas_result_t'(m_axis_tdata[6:0]);
				if (pending_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected output transaction, expected none, actual %h",
						$time, m_axis_tdata);
				end else begin
					want = pending_results.pop_front();
					cmp_field("step_out", want.step_out, got.step_out);
					cmp_field("dir_out", want.dir_out, got.dir_out);
					cmp_field("spindle_on", want.spindle_on, got.spindle_on);
					cmp_field("mode_now", want.mode_now, got.mode_now);
					ticks_checked++;
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want = sequencer_tick(sdas_item_t'(s_axis_tdata));
				modes_hit[want.mode_now] = 1'b1;
				pending_results.push_back(want);
			end
			outstanding = pending_results.size();
		end
	end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the drill axis sequencer: directed ticks through
// every mode, then sticky random button/switch traffic with remote commands
// under several register settings, idle patterns and backpressure.
// ----------------------------------------------------------------------------
module tb_top;
	import sdas_pkg::*;

	localparam int IDLE_LIMIT = 4000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [InDataW-1:0]   s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OutDataW-1:0]  m_axis_tdata;
	logic                 cfg_we = 1'b0;
	logic [CfgIndexW-1:0] cfg_index = REG_DRILL_STEP_LIMIT;
	logic [CfgDataW-1:0]  cfg_data = '0;

	int          fail_count;
	int          outstanding;
	int          ticks_checked;
	logic [15:0] modes_hit;

	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	bit   long_hold = 1'b0;
	int   settings_used = 0;
	int   idle_cycles = 0;
	logic held_f = 1'b0;
	logic held_b = 1'b0;
	logic held_d = 1'b0;
	logic held_sw = 1'b1;

	stepper_drill_axis_sequencer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	sdas_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.ticks_checked (ticks_checked),
		.modes_hit     (modes_hit)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold) begin
				m_axis_tready <= 1'b0;
				repeat (300) @(posedge clk);
				long_hold = 1'b0;
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog: cycles with no transaction on either stream
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic sdas_item_t mk(input logic f, input logic b, input logic d,
		input logic sw, input logic rv, input logic [2:0] cmd);
		sdas_item_t it;
		it.fwd_pressed      = f;
		it.back_pressed     = b;
		it.drill_pressed    = d;
		it.end_switch_level = sw;
		it.remote_valid     = rv;
		it.remote_cmd       = cmd;
		return it;
	endfunction

	// called just after a rising edge; returns just after the accepting edge
	task automatic send_tick(input sdas_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= it;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// outstanding is sampled on the falling edge to stay clear of the checker
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	task automatic reconfigure(input logic [15:0] limit, input logic [7:0] burst,
		input logic [7:0] half, input logic [7:0] poll);
		drain();
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_DRILL_STEP_LIMIT;
		cfg_data  <= limit;
		@(posedge clk);
		cfg_index <= REG_JOG_BURST_STEPS;
		cfg_data  <= {8'd0, burst};
		@(posedge clk);
		cfg_index <= REG_HALF_PERIOD_TICKS;
		cfg_data  <= {8'd0, half};
		@(posedge clk);
		cfg_index <= REG_RELEASE_POLL_TICKS;
		cfg_data  <= {8'd0, poll};
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// buttons and switch are held for runs of ticks so that motion gets going
	task automatic run_random(input int n);
		sdas_item_t it;
		for (int i = 0; i < n; i++) begin
			held_f = held_f ? ($urandom_range(3) != 0) : ($urandom_range(14) == 0);
			held_b = held_b ? ($urandom_range(3) != 0) : ($urandom_range(14) == 0);
			held_d = held_d ? ($urandom_range(1) == 0) : ($urandom_range(19) == 0);
			if ($urandom_range(4) == 0)
				held_sw = !held_sw;
			it = mk(held_f, held_b, held_d, held_sw, ($urandom_range(11) == 0),
				($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(3)));
			if ($urandom_range(9) == 0)
				it = sdas_item_t'(8'($urandom));
			send_tick(it);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero registers behave as one; short drill limit
		reconfigure(16'd2, 8'd0, 8'd0, 8'd0);
		send_tick(mk(0, 0, 0, 1, 0, CMD_FWD));
		send_tick(mk(0, 0, 0, 1, 0, CMD_FWD));
		send_tick(mk(0, 0, 0, 0, 0, CMD_FWD));
		send_tick(mk(0, 0, 0, 0, 0, CMD_FWD));
		send_tick(mk(0, 0, 0, 1, 0, CMD_FWD));
		send_tick(mk(0, 0, 0, 1, 0, CMD_FWD));
		send_tick(mk(0, 0, 0, 1, 1, 3'd7));
		send_tick(mk(0, 0, 0, 1, 1, 3'd4));
		send_tick(mk(0, 0, 0, 1, 1, CMD_FWD));
		send_tick(mk(0, 0, 0, 1, 0, CMD_FWD));
		send_tick(mk(0, 0, 0, 0, 1, CMD_BACK));
		send_tick(mk(0, 0, 0, 0, 1, CMD_STOP));
		send_tick(mk(1, 0, 0, 0, 0, CMD_FWD));
		send_tick(mk(1, 1, 0, 0, 0, CMD_FWD));
		send_tick(mk(0, 0, 0, 0, 0, CMD_FWD));
		send_tick(mk(1, 0, 0, 1, 0, CMD_FWD));
		send_tick(mk(1, 0, 0, 1, 0, CMD_FWD));
		send_tick(mk(0, 1, 0, 0, 0, CMD_FWD));
		send_tick(mk(0, 0, 1, 1, 0, CMD_FWD));
		send_tick(mk(0, 0, 0, 1, 0, CMD_FWD));
		send_tick(mk(0, 0, 0, 0, 0, CMD_FWD));
		send_tick(mk(0, 0, 0, 0, 0, CMD_FWD));
		send_tick(mk(0, 0, 0, 0, 0, CMD_FWD));
		send_tick(mk(0, 0, 0, 1, 1, CMD_DRILL));
		send_tick(mk(1, 1, 1, 1, 0, CMD_FWD));

		reconfigure(16'hFFFF, 8'd255, 8'd1, 8'd1);
		run_random(80);

		send_idle_pct = 85;
		reconfigure(16'd3, 8'd2, 8'd2, 8'd3);
		run_random(80);

		send_idle_pct  = 0;
		recv_stall_pct = 85;
		reconfigure(16'd0, 8'd1, 8'd1, 8'd255);
		run_random(80);

		send_idle_pct  = 19;
		recv_stall_pct = 19;
		reconfigure(16'd1, 8'd255, 8'd255, 8'd10);
		run_random(60);

		// backpressure fills the block; then a full drain mid-phase
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		reconfigure(16'd4, 8'd4, 8'd1, 8'd2);
		long_hold = 1'b1;
		run_random(40);
		drain();
		run_random(40);

		send_idle_pct  = 19;
		recv_stall_pct = 19;
		reconfigure(16'd8, 8'd5, 8'd3, 8'd1);
		run_random(80);

		drain();
		repeat (4) @(posedge clk);
		$display("Summary: %0d ticks checked across %0d register settings", ticks_checked,
			settings_used);
		$display("Summary: modes reached (bit per mode) %b", modes_hit[8:0]);
		if (fail_count == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
